// ===== rtl/led_matrix_scan_driver_assert.svh =====
// ----------------------------------------------------------------------------
// LED matrix scan driver assertion macros
// Property wrappers for the scan driver checker.
// ----------------------------------------------------------------------------
`ifndef LED_MATRIX_SCAN_DRIVER_ASSERT_SVH
`define LED_MATRIX_SCAN_DRIVER_ASSERT_SVH

// same-cycle implication, disabled while reset is high
`define LMSD_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, disabled while reset is high
`define LMSD_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== rtl/lmsd_pkg.sv =====
// ----------------------------------------------------------------------------
// LED matrix scan driver package
// Geometry constants, derived widths, command, operation and state codes,
// and the structs that join the controller to the datapath.
// ----------------------------------------------------------------------------
package lmsd_pkg;

   localparam int ROWS    = 16;
   localparam int COLUMNS = 16;
   localparam int PANELS  = 6;

   localparam int SUBPIX = COLUMNS * 3;
   localparam int CELLS  = ROWS * SUBPIX;
   localparam int SUB_W  = $clog2(SUBPIX);
   localparam int CELL_W = (CELLS > 1) ? $clog2(CELLS) : 1;

   // fixed field widths of the ports and the phase counter
   localparam int CMD_W    = 2;
   localparam int PANEL_W  = 3;
   localparam int COORD_W  = 4;
   localparam int SERIAL_W = 6;
   localparam int ROW_W    = 4;
   localparam int PHASE_W  = 4;

   localparam int PHASE_MOD = 9;

   typedef logic [PANELS-1:0]   panel_vec_type;
   typedef logic [SUB_W-1:0]    sub_type;
   typedef logic [CELL_W-1:0]   cell_addr_type;
   typedef logic [ROW_W-1:0]    row_type;
   typedef logic [PHASE_W-1:0]  phase_type;
   typedef logic [SERIAL_W-1:0] serial_type;
   typedef logic [5:0]          x3_type;

   localparam panel_vec_type PANEL_MASK = '1;

   typedef enum logic [CMD_W-1:0] {
      CMD_SET   = 2'd0,
      CMD_CLEAR = 2'd1,
      CMD_SCAN  = 2'd2,
      CMD_NONE  = 2'd3
   } cmd_type;

   typedef enum logic [2:0] {
      OP_INIT,
      OP_SET,
      OP_CLEAR,
      OP_SCAN,
      OP_COPY,
      OP_LATCH
   } op_type;

   typedef enum logic [2:0] {
      ST_INIT,
      ST_IDLE,
      ST_SET,
      ST_CLEAR,
      ST_SCAN,
      ST_LATCH,
      ST_COPY
   } state_type;

   typedef struct packed {
      logic   load;
      op_type op;
      logic   issue;
      logic   latch_go;
   } ctrl_cmd_type;

   typedef struct packed {
      logic last_issue;
      logic set_ok;
      logic clear_ok;
      logic wrap;
      logic s1_busy;
   } dp_status_type;

endpackage

// ===== rtl/led_matrix_scan_driver.sv =====
// ----------------------------------------------------------------------------
// LED matrix scan driver
// Scan driver for six multiplexed 16x16 RGB panels fed through shift
// registers: pixel draw store, display store and row scan sequencer.
// ----------------------------------------------------------------------------
// A transaction is taken when start is high and busy is low. Right after
// reset busy stays high while an init pass writes every word of both
// stores (draw to zero, display to the startup pattern). A set pixel and a
// clear panel occupy the block while their store words are swept, one store
// word per cycle. A scan tick puts 48 shift results and then one latch
// result on the rsp_ ports, one per cycle, once the first store read has
// passed the sweep and result registers; the next transaction can be taken
// once the latch result has been shown, and a tick on the last row first
// adds the word-by-word copy of the draw store into the display store. This
// pacing follows from the single read port of each store. Results are never
// held: each is valid for the one cycle in which rsp_strobe is high.
module led_matrix_scan_driver (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   output logic                         busy,
   input  logic [lmsd_pkg::CMD_W-1:0]   req_cmd,
   input  logic [lmsd_pkg::PANEL_W-1:0] req_panel_index,
   input  logic [lmsd_pkg::COORD_W-1:0] req_column_x,
   input  logic [lmsd_pkg::COORD_W-1:0] req_row_y,
   input  logic                         req_red,
   input  logic                         req_green,
   input  logic                         req_blue,
   output logic                         rsp_strobe,
   output logic                         rsp_kind,
   output logic [lmsd_pkg::SERIAL_W-1:0] rsp_serial_bits,
   output logic [lmsd_pkg::ROW_W-1:0]   rsp_row_select,
   output logic                         rsp_last
);

   lmsd_pkg::ctrl_cmd_type  cmd;
   lmsd_pkg::dp_status_type status;

   lmsd_ctrl u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .start  (start),
      .req_cmd(lmsd_pkg::cmd_type'(req_cmd)),
      .status (status),
      .cmd    (cmd),
      .busy   (busy)
   );

   lmsd_datapath u_datapath (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .status         (status),
      .req_panel_index(req_panel_index),
      .req_column_x   (req_column_x),
      .req_row_y      (req_row_y),
      .req_red        (req_red),
      .req_green      (req_green),
      .req_blue       (req_blue),
      .rsp_strobe     (rsp_strobe),
      .rsp_kind       (rsp_kind),
      .rsp_serial_bits(rsp_serial_bits),
      .rsp_row_select (rsp_row_select),
      .rsp_last       (rsp_last)
   );

endmodule

// ===== rtl/lmsd_ram.sv =====
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module lmsd_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

// ===== rtl/lmsd_ctrl.sv =====
// ----------------------------------------------------------------------------
// LED matrix scan driver controller
// Sequences the init pass, pixel writes, panel clears, row scans and the
// store copy that follows the last row.
// ----------------------------------------------------------------------------
module lmsd_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   input  lmsd_pkg::cmd_type       req_cmd,
   input  lmsd_pkg::dp_status_type status,
   output lmsd_pkg::ctrl_cmd_type  cmd,
   output logic                    busy
);

   lmsd_pkg::state_type state_ff, state_in;
   logic                accept;

   assign busy   = (state_ff != lmsd_pkg::ST_IDLE) || status.s1_busy;
   assign accept = start && !busy;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= lmsd_pkg::ST_INIT;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         lmsd_pkg::ST_INIT, lmsd_pkg::ST_SET, lmsd_pkg::ST_CLEAR, lmsd_pkg::ST_COPY: begin
            if (status.last_issue) begin
               state_in = lmsd_pkg::ST_IDLE;
            end
         end
         lmsd_pkg::ST_IDLE: begin
            if (accept) begin
               case (req_cmd)
                  lmsd_pkg::CMD_SET: begin
                     if (status.set_ok) begin
                        state_in = lmsd_pkg::ST_SET;
                     end
                  end
                  lmsd_pkg::CMD_CLEAR: begin
                     if (status.clear_ok) begin
                        state_in = lmsd_pkg::ST_CLEAR;
                     end
                  end
                  lmsd_pkg::CMD_SCAN: state_in = lmsd_pkg::ST_SCAN;
                  default:            state_in = lmsd_pkg::ST_IDLE;
               endcase
            end
         end
         lmsd_pkg::ST_SCAN: begin
            if (status.last_issue) begin
               state_in = lmsd_pkg::ST_LATCH;
            end
         end
         lmsd_pkg::ST_LATCH: begin
            state_in = status.wrap ? lmsd_pkg::ST_COPY : lmsd_pkg::ST_IDLE;
         end
         default: state_in = lmsd_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      cmd.load     = 1'b0;
      cmd.op       = lmsd_pkg::OP_SCAN;
      cmd.issue    = 1'b0;
      cmd.latch_go = 1'b0;
      case (state_ff)
         lmsd_pkg::ST_INIT, lmsd_pkg::ST_SET, lmsd_pkg::ST_CLEAR,
         lmsd_pkg::ST_SCAN, lmsd_pkg::ST_COPY: begin
            cmd.issue = 1'b1;
         end
         lmsd_pkg::ST_IDLE: begin
            cmd.load = accept;
            case (req_cmd)
               lmsd_pkg::CMD_SET:   cmd.op = lmsd_pkg::OP_SET;
               lmsd_pkg::CMD_CLEAR: cmd.op = lmsd_pkg::OP_CLEAR;
               default:             cmd.op = lmsd_pkg::OP_SCAN;
            endcase
         end
         lmsd_pkg::ST_LATCH: begin
            cmd.latch_go = 1'b1;
            // arm the draw-to-display copy after the last row
            cmd.load     = status.wrap;
            cmd.op       = lmsd_pkg::OP_COPY;
         end
         default: begin
            cmd.load = 1'b0;
         end
      endcase
   end

endmodule

// ===== rtl/lmsd_datapath.sv =====
// ----------------------------------------------------------------------------
// LED matrix scan driver datapath
// Address sweep counters, draw and display stores, and the write-back and
// result stage in the cycle after the store reads.
// ----------------------------------------------------------------------------
module lmsd_datapath (
   input  logic                        clock,
   input  logic                        reset,
   input  lmsd_pkg::ctrl_cmd_type      cmd,
   output lmsd_pkg::dp_status_type     status,
   input  logic [lmsd_pkg::PANEL_W-1:0] req_panel_index,
   input  logic [lmsd_pkg::COORD_W-1:0] req_column_x,
   input  logic [lmsd_pkg::COORD_W-1:0] req_row_y,
   input  logic                        req_red,
   input  logic                        req_green,
   input  logic                        req_blue,
   output logic                        rsp_strobe,
   output logic                        rsp_kind,
   output lmsd_pkg::serial_type        rsp_serial_bits,
   output lmsd_pkg::row_type           rsp_row_select,
   output logic                        rsp_last
);

   // sweep state
   lmsd_pkg::op_type                op_ff, op_in;
   lmsd_pkg::row_type               row_ff, row_in;
   lmsd_pkg::sub_type               sub_ff, sub_in;
   lmsd_pkg::sub_type               sub_lo_ff, sub_lo_in;
   lmsd_pkg::phase_type             phase_ff, phase_in;
   lmsd_pkg::row_type               scan_row_ff, scan_row_in;
   logic [lmsd_pkg::PANEL_W-1:0]    panel_ff;
   logic [2:0]                      rgb_ff;

   // write-back / result stage
   logic                            s1_valid_ff, s1_valid_in;
   lmsd_pkg::op_type                s1_op_ff;
   lmsd_pkg::cell_addr_type         s1_addr_ff;
   lmsd_pkg::phase_type             s1_phase_ff;
   logic [1:0]                      s1_color_ff;
   lmsd_pkg::row_type               s1_row_ff;

   lmsd_pkg::x3_type                x3;
   lmsd_pkg::sub_type               x3_sub;
   lmsd_pkg::cell_addr_type         rd_addr;
   logic                            full_sweep;
   logic                            sub_at_lo;
   logic [1:0]                      color;
   lmsd_pkg::panel_vec_type         bit_sel;
   lmsd_pkg::panel_vec_type         draw_rd, disp_rd;
   lmsd_pkg::panel_vec_type         draw_wr, disp_wr;
   logic                            draw_we, disp_we;
   logic                            pattern_on;

   assign x3     = lmsd_pkg::x3_type'(req_column_x) * lmsd_pkg::x3_type'(3);
   assign x3_sub = lmsd_pkg::sub_type'(x3);

   assign status.set_ok   = (int'(req_panel_index) < lmsd_pkg::PANELS) &&
                            (int'(req_row_y) < lmsd_pkg::ROWS) &&
                            (int'(req_column_x) < lmsd_pkg::COLUMNS);
   assign status.clear_ok = int'(req_panel_index) < lmsd_pkg::PANELS;
   assign status.wrap     = int'(scan_row_ff) >= lmsd_pkg::ROWS - 1;
   assign status.s1_busy  = s1_valid_ff;

   assign full_sweep = (op_ff == lmsd_pkg::OP_INIT) || (op_ff == lmsd_pkg::OP_CLEAR) ||
                       (op_ff == lmsd_pkg::OP_COPY);
   assign sub_at_lo  = sub_ff == sub_lo_ff;
   assign status.last_issue = sub_at_lo &&
                              (!full_sweep || int'(row_ff) == lmsd_pkg::ROWS - 1);

   assign rd_addr = lmsd_pkg::cell_addr_type'(row_ff) *
                    lmsd_pkg::cell_addr_type'(lmsd_pkg::SUBPIX) +
                    lmsd_pkg::cell_addr_type'(sub_ff);
   assign color   = 2'(sub_ff - sub_lo_ff);

   always_comb begin
      op_in       = op_ff;
      row_in      = row_ff;
      sub_in      = sub_ff;
      sub_lo_in   = sub_lo_ff;
      phase_in    = phase_ff;
      scan_row_in = scan_row_ff;
      if (cmd.load) begin
         op_in    = cmd.op;
         phase_in = '0;
         case (cmd.op)
            lmsd_pkg::OP_SET: begin
               row_in    = lmsd_pkg::row_type'(req_row_y);
               sub_in    = x3_sub + lmsd_pkg::sub_type'(2);
               sub_lo_in = x3_sub;
            end
            lmsd_pkg::OP_SCAN: begin
               row_in    = scan_row_ff;
               sub_in    = lmsd_pkg::sub_type'(lmsd_pkg::SUBPIX - 1);
               sub_lo_in = '0;
            end
            default: begin
               row_in    = '0;
               sub_in    = lmsd_pkg::sub_type'(lmsd_pkg::SUBPIX - 1);
               sub_lo_in = '0;
            end
         endcase
      end else if (cmd.issue) begin
         if (sub_at_lo) begin
            row_in   = row_ff + lmsd_pkg::row_type'(1);
            sub_in   = lmsd_pkg::sub_type'(lmsd_pkg::SUBPIX - 1);
            phase_in = '0;
         end else begin
            sub_in   = sub_ff - lmsd_pkg::sub_type'(1);
            phase_in = (int'(phase_ff) == lmsd_pkg::PHASE_MOD - 1) ? '0 :
                       phase_ff + lmsd_pkg::phase_type'(1);
         end
      end
      if (cmd.latch_go) begin
         scan_row_in = status.wrap ? '0 : scan_row_ff + lmsd_pkg::row_type'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         op_ff       <= lmsd_pkg::OP_INIT;
         row_ff      <= '0;
         sub_ff      <= lmsd_pkg::sub_type'(lmsd_pkg::SUBPIX - 1);
         sub_lo_ff   <= '0;
         phase_ff    <= '0;
         scan_row_ff <= '0;
         s1_valid_ff <= 1'b0;
      end else begin
         op_ff       <= op_in;
         row_ff      <= row_in;
         sub_ff      <= sub_in;
         sub_lo_ff   <= sub_lo_in;
         phase_ff    <= phase_in;
         scan_row_ff <= scan_row_in;
         s1_valid_ff <= s1_valid_in;
      end
   end

   assign s1_valid_in = cmd.issue || cmd.latch_go;

   // payload registers
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         panel_ff <= req_panel_index;
         rgb_ff   <= {req_blue, req_green, req_red};
      end
      s1_op_ff    <= cmd.latch_go ? lmsd_pkg::OP_LATCH : op_ff;
      s1_addr_ff  <= rd_addr;
      s1_phase_ff <= phase_ff;
      s1_color_ff <= color;
      s1_row_ff   <= scan_row_ff;
   end

   assign bit_sel    = lmsd_pkg::panel_vec_type'(1) << panel_ff;
   assign pattern_on = (s1_phase_ff == lmsd_pkg::phase_type'(0)) ||
                       (s1_phase_ff == lmsd_pkg::phase_type'(4)) ||
                       (s1_phase_ff == lmsd_pkg::phase_type'(8));

   always_comb begin
      draw_we = 1'b0;
      disp_we = 1'b0;
      draw_wr = draw_rd & ~bit_sel;
      disp_wr = draw_rd;
      if (s1_valid_ff) begin
         case (s1_op_ff)
            lmsd_pkg::OP_INIT: begin
               draw_we = 1'b1;
               disp_we = 1'b1;
               draw_wr = '0;
               disp_wr = pattern_on ? lmsd_pkg::PANEL_MASK : '0;
            end
            lmsd_pkg::OP_SET: begin
               draw_we = 1'b1;
               draw_wr = (draw_rd & ~bit_sel) | (rgb_ff[s1_color_ff] ? bit_sel : '0);
            end
            lmsd_pkg::OP_CLEAR: draw_we = 1'b1;
            lmsd_pkg::OP_COPY:  disp_we = 1'b1;
            default:            draw_we = 1'b0;
         endcase
      end
   end

   lmsd_ram #(
      .WIDTH(lmsd_pkg::PANELS),
      .DEPTH(lmsd_pkg::CELLS)
   ) u_draw_ram (
      .clock  (clock),
      .wr_en  (draw_we),
      .wr_addr(s1_addr_ff),
      .wr_data(draw_wr),
      .rd_en  (cmd.issue),
      .rd_addr(rd_addr),
      .rd_data(draw_rd)
   );

   lmsd_ram #(
      .WIDTH(lmsd_pkg::PANELS),
      .DEPTH(lmsd_pkg::CELLS)
   ) u_disp_ram (
      .clock  (clock),
      .wr_en  (disp_we),
      .wr_addr(s1_addr_ff),
      .wr_data(disp_wr),
      .rd_en  (cmd.issue),
      .rd_addr(rd_addr),
      .rd_data(disp_rd)
   );

   always_comb begin
      rsp_strobe      = 1'b0;
      rsp_kind        = 1'b0;
      rsp_serial_bits = '0;
      rsp_row_select  = s1_row_ff;
      rsp_last        = 1'b0;
      if (s1_valid_ff) begin
         case (s1_op_ff)
            lmsd_pkg::OP_SCAN: begin
               rsp_strobe      = 1'b1;
               rsp_serial_bits = lmsd_pkg::serial_type'(disp_rd);
            end
            lmsd_pkg::OP_LATCH: begin
               rsp_strobe = 1'b1;
               rsp_kind   = 1'b1;
               rsp_last   = 1'b1;
            end
            default: rsp_strobe = 1'b0;
         endcase
      end
   end

endmodule

// ===== rtl/lmsd_checker.sv =====
// ----------------------------------------------------------------------------
// LED matrix scan driver checker
// Port-level properties of the scan driver, bound to the top level.
// ----------------------------------------------------------------------------
`include "led_matrix_scan_driver_assert.svh"

module lmsd_checker (
   input logic                          clock,
   input logic                          reset,
   input logic                          start,
   input logic                          busy,
   input logic [lmsd_pkg::CMD_W-1:0]    req_cmd,
   input logic                          rsp_strobe,
   input logic                          rsp_kind,
   input logic [lmsd_pkg::SERIAL_W-1:0] rsp_serial_bits,
   input logic                          rsp_last
);

   `LMSD_ASSERT_NOW(a_latch_fields, clock, reset, rsp_strobe && rsp_kind, rsp_last && (rsp_serial_bits == '0), "latch result without last or with serial data")
   `LMSD_ASSERT_NOW(a_shift_not_last, clock, reset, rsp_strobe && !rsp_kind, !rsp_last, "shift result marked last")
   `LMSD_ASSERT_NEXT(a_latch_ends_tick, clock, reset, rsp_strobe && rsp_last, !rsp_strobe, "result right after the latch")
   `LMSD_ASSERT_NEXT(a_tick_goes_busy, clock, reset, start && !busy && (req_cmd == lmsd_pkg::CMD_SCAN), busy, "scan tick taken but block not busy")
   `LMSD_ASSERT_NOW(a_result_while_busy, clock, reset, rsp_strobe, busy, "result while idle")

endmodule

bind led_matrix_scan_driver lmsd_checker u_lmsd_checker (
   .clock          (clock),
   .reset          (reset),
   .start          (start),
   .busy           (busy),
   .req_cmd        (req_cmd),
   .rsp_strobe     (rsp_strobe),
   .rsp_kind       (rsp_kind),
   .rsp_serial_bits(rsp_serial_bits),
   .rsp_last       (rsp_last)
);
